// ===== rtl/prp_ti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_ti_pkg
// Shared types and constants for the redundancy trailer inserter.
// ----------------------------------------------------------------------------
package prp_ti_pkg;

  localparam int CNT_W = 12;
  localparam int SEQ_W = 16;
  localparam int PAD_W = 6;

  localparam logic [CNT_W-1:0] HDR_BYTES = 12'd14;
  localparam logic [CNT_W-1:0] TRL_BYTES = 12'd6;
  localparam logic [CNT_W-1:0] COUNT_MAX = 12'hFFF;
  localparam logic [PAD_W-1:0] PAD_LIMIT = 6'd57;

  localparam logic [3:0] LAN_A_TAG = 4'hA;
  localparam logic [3:0] LAN_B_TAG = 4'hB;
  localparam logic [7:0] SUFFIX_HI = 8'h88;
  localparam logic [7:0] SUFFIX_LO = 8'hFB;

  // Trailer byte positions
  localparam logic [2:0] TRL_SEQ_HI  = 3'd0;
  localparam logic [2:0] TRL_SEQ_LO  = 3'd1;
  localparam logic [2:0] TRL_MID_HI  = 3'd2;
  localparam logic [2:0] TRL_MID_LO  = 3'd3;
  localparam logic [2:0] TRL_SUF_HI  = 3'd4;
  localparam logic [2:0] TRL_SUF_LO  = 3'd5;

  typedef enum logic [0:0] {
    REG_LAN_SELECT = 1'b0,
    REG_MIN_FRAME  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAD,
    PH_TRAIL
  } phase_t;

  // Frame-end request from the byte path to the tail sequencer
  typedef struct packed {
    logic             start;
    logic [PAD_W-1:0] pad;
    logic [CNT_W-1:0] size;
    logic             lan_b;
  } tail_req_t;

  // One padding or trailer beat offered to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } tail_beat_t;

endpackage

// ===== rtl/prp_ti_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_ti_tail
// Padding and trailer sequencer: emits zero pad beats, then the six trailer
// beats, one per free output slot; owns the frame sequence counter.
// ----------------------------------------------------------------------------
module prp_ti_tail
  import prp_ti_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tail_req_t  req,
  input  logic       slot_free,
  output logic       busy,
  output tail_beat_t beat
);

  phase_t           phase_r, phase_nxt;
  logic [PAD_W-1:0] pad_r, pad_nxt;
  logic [2:0]       idx_r, idx_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [CNT_W-1:0] size_r;
  logic             lan_b_r;
  logic [15:0]      mid;
  logic [7:0]       trl_byte;

  assign mid = {(lan_b_r ? LAN_B_TAG : LAN_A_TAG), size_r};

  // Select trailer byte by position
  always_comb begin
    case (idx_r)
      TRL_SEQ_HI: trl_byte = seq_r[15:8];
      TRL_SEQ_LO: trl_byte = seq_r[7:0];
      TRL_MID_HI: trl_byte = mid[15:8];
      TRL_MID_LO: trl_byte = mid[7:0];
      TRL_SUF_HI: trl_byte = SUFFIX_HI;
      TRL_SUF_LO: trl_byte = SUFFIX_LO;
      default:    trl_byte = 8'h00;
    endcase
  end

  // Advance through padding and trailer
  always_comb begin
    phase_nxt  = phase_r;
    pad_nxt    = pad_r;
    idx_nxt    = idx_r;
    seq_nxt    = seq_r;
    beat.valid = 1'b0;
    beat.data  = 8'h00;
    beat.last  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          pad_nxt   = req.pad;
          idx_nxt   = TRL_SEQ_HI;
          phase_nxt = (req.pad != '0) ? PH_PAD : PH_TRAIL;
        end
      end
      PH_PAD: begin
        if (slot_free) begin
          beat.valid = 1'b1;
          pad_nxt    = pad_r - 1'b1;
          if (pad_r == PAD_W'(1)) begin
            phase_nxt = PH_TRAIL;
          end
        end
      end
      PH_TRAIL: begin
        if (slot_free) begin
          beat.valid = 1'b1;
          beat.data  = trl_byte;
          idx_nxt    = idx_r + 1'b1;
          if (idx_r == TRL_SUF_LO) begin
            beat.last = 1'b1;
            seq_nxt   = seq_r + 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign busy = (phase_r != PH_IDLE);

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pad_r   <= '0;
      idx_r   <= '0;
      seq_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
      idx_r   <= idx_nxt;
      seq_r   <= seq_nxt;
    end
  end

  // Capture trailer fields at frame end
  always_ff @(posedge clk) begin
    if (req.start && phase_r == PH_IDLE) begin
      size_r  <= req.size;
      lan_b_r <= req.lan_b;
    end
  end

endmodule

// ===== rtl/prp_trailer_inserter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_trailer_inserter
// Appends zero padding and the six-byte redundancy trailer to a byte stream.
// ----------------------------------------------------------------------------
// Frame bytes pass through one beat per cycle into a single output register
// whose slot frees whenever the consumer takes the current beat, so input
// is taken every cycle while the output side keeps up. On the beat marked
// frame_end the tail sequencer takes over the output register for its pad
// beats and six trailer beats (pad at most 57), while in_ready is low. Bytes past
// MAX_FRAME_BYTES in one frame are taken and dropped. The trailer carries the
// sequence number, the LAN tag over the 12-bit size (payload + 6, saturating),
// and 0x88 0xFB. Configuration writes are taken at any time (cfg_ready is
// always high) and must happen only while the block is idle.
// ----------------------------------------------------------------------------
module prp_trailer_inserter
  import prp_ti_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [CNT_W:0] MAX_BYTES = (CNT_W+1)'(MAX_FRAME_BYTES);

  logic             lan_select_r;
  logic [7:0]       min_frame_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             slot_free;
  logic             acc;
  logic             pass_ok;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   total;
  logic [CNT_W:0]   pad_full;
  logic [CNT_W-1:0] payload;
  logic [CNT_W:0]   size_full;
  tail_req_t        req;
  tail_beat_t       tbeat;
  logic             tail_busy;

  // Configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lan_select_r <= 1'b0;
      min_frame_r  <= 8'd60;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LAN_SELECT: lan_select_r <= cfg_data[0];
        REG_MIN_FRAME:  min_frame_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = slot_free && !tail_busy;
  assign acc       = in_valid && in_ready;

  // Count frame bytes, drop past the size limit
  assign pass_ok   = {1'b0, count_r} < MAX_BYTES;
  assign count_inc = (pass_ok && count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;

  always_comb begin
    count_nxt = count_r;
    if (acc) begin
      count_nxt = in_frame_end ? '0 : count_inc;
    end
  end

  // Padding and size for the trailer
  assign total    = {1'b0, count_inc} + {1'b0, TRL_BYTES};
  assign pad_full = (total < {5'd0, min_frame_r}) ? {5'd0, min_frame_r} - total : '0;
  assign payload  = (count_inc >= HDR_BYTES) ? count_inc - HDR_BYTES : '0;
  assign size_full = {1'b0, payload} + {1'b0, TRL_BYTES};

  always_comb begin
    req.start = acc && in_frame_end;
    req.pad   = (pad_full > {7'd0, PAD_LIMIT}) ? PAD_LIMIT : pad_full[PAD_W-1:0];
    req.size  = size_full[CNT_W] ? COUNT_MAX : size_full[CNT_W-1:0];
    req.lan_b = lan_select_r;
  end

  prp_ti_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .slot_free(slot_free),
    .busy     (tail_busy),
    .beat     (tbeat)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if ((acc && pass_ok) || tbeat.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Load frame beat or tail beat
  always_ff @(posedge clk) begin
    if (acc && pass_ok) begin
      out_byte_r <= in_data_byte;
      out_last_r <= 1'b0;
    end else if (tbeat.valid) begin
      out_byte_r <= tbeat.data;
      out_last_r <= tbeat.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
